/* src/wsfi_pkg.sv */
// ----------------------------------------------------------------------------
// wsfi_pkg - shared types and constants
// Item, result, job, configuration and back-end state types plus fixed-point limits.
// ----------------------------------------------------------------------------
package wsfi_pkg;

    localparam int GRID_DIM_DEF  = 1024;
    localparam int MAX_STEPS_DEF = 1024;
    localparam int QDEPTH        = 2;

    // iterative unit widths
    localparam int SQ_W  = 56;
    localparam int NUM_W = 48;
    localparam int DEN_W = 56;

    localparam logic [7:0]  STEP_RST = 8'd26;
    localparam logic [15:0] EXCL_RST = 16'd256;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCL = 1'b1;

    localparam logic [62:0]        SUM_CAP     = 63'h4000_0000_0000_0000;
    localparam logic [47:0]        CONTRIB_CAP = 48'h8000_0000_0000;
    localparam logic signed [49:0] FIELD_MAX   = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] FIELD_MIN   = 50'sh3_8000_0000_0000;

    typedef struct packed {
        logic [9:0]         point_x;
        logic [9:0]         point_y;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic signed [31:0] current;
        logic signed [47:0] prior_field;
        logic               restart;
    } t_item;

    typedef struct packed {
        logic signed [47:0] field_value;
        logic signed [47:0] peak_value;
        logic               step_overflow;
    } t_result;

    typedef struct packed {
        logic [7:0]  step_length;
        logic [15:0] exclusion_radius;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic [17:0]        px_q;
        logic [17:0]        py_q;
        logic signed [23:0] x0;
        logic signed [23:0] y0;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic signed [31:0] cur;
        logic signed [47:0] prior;
        logic               restart;
    } t_job;

    typedef enum logic [4:0] {
        S_IDLE, S_LMX, S_LMY, S_LSQ, S_LSQW, S_DXD, S_DXW, S_DYD, S_DYW,
        S_SAMP, S_WX, S_FU, S_WY, S_FV, S_RR1, S_RR2, S_RSQ, S_RSQW,
        S_CR1, S_CR2, S_SND, S_SNW, S_TM, S_TMD, S_TMW, S_CM, S_FLD
    } t_bstate;

endpackage

/* src/wire_segment_field_integrator.sv */
// ----------------------------------------------------------------------------
// wire_segment_field_integrator - field of one wire segment at a grid point
// Front end queues items, back end integrates along the segment.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low; a two-entry
// job queue sits between the intake and the integration engine, so busy only
// rises when two items already wait. Each item produces exactly one result,
// shown for one cycle with o_valid; the receiver cannot stall it. The work
// per item grows with the samples walked (ceil(len/step), at most MAX_STEPS)
// and with the samples not excluded by radius. It is set by the shared
// divider (one quotient bit per cycle, two divides per kept sample) and the
// square root unit.
// The user must write configuration (index 0 step_length, 1 exclusion_radius)
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wire_segment_field_integrator #(
    parameter int GRID_DIM  = wsfi_pkg::GRID_DIM_DEF,
    parameter int MAX_STEPS = wsfi_pkg::MAX_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  wsfi_pkg::t_item                  i_item,
    input  logic                             i_cfg_we,
    input  logic [wsfi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                      i_cfg_data,
    output logic                             o_valid,
    output wsfi_pkg::t_result                o_result
);
    wsfi_pkg::t_cfg r_cfg;
    wsfi_pkg::t_job q_job;
    logic           q_full, q_valid, q_pop, push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_length      <= wsfi_pkg::STEP_RST;
            r_cfg.exclusion_radius <= wsfi_pkg::EXCL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wsfi_pkg::CFG_STEP: r_cfg.step_length      <= i_cfg_data[7:0];
                wsfi_pkg::CFG_EXCL: r_cfg.exclusion_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // transfer in happens whenever start is high and the queue has room
    assign push = start && !q_full;
    assign busy = q_full;

    wsfi_front #(.GRID_DIM(GRID_DIM)) u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .i_item(i_item), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_job(q_job)
    );

    wsfi_back #(.MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk, .i_rst_n,
        .i_cfg(r_cfg), .i_q_valid(q_valid), .i_job(q_job), .o_pop(q_pop),
        .o_valid(o_valid), .o_result(o_result)
    );

endmodule

/* src/wsfi_sqrt.sv */
// ----------------------------------------------------------------------------
// wsfi_sqrt - iterative integer square root
// Two radicand bits per cycle, one-cycle done pulse.
// ----------------------------------------------------------------------------
module wsfi_sqrt #(
    parameter int W = wsfi_pkg::SQ_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_rad,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);
    localparam int CW = $clog2(W/2 + 1);

    logic [W-1:0]  r_v, r_res, r_bit, n_v, n_res, trial;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    always_comb begin
        trial = r_res + r_bit;
        if (r_v >= trial) begin
            n_v   = r_v - trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_v   = r_v;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start)
                r_cnt <= CW'(W/2);
            else if (r_cnt != '0)
                r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_rad;
            r_res <= '0;
            r_bit <= W'(1) << (W-2);
        end else if (r_cnt != '0) begin
            r_v   <= n_v;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[W/2-1:0];

endmodule

/* src/wsfi_div.sv */
// ----------------------------------------------------------------------------
// wsfi_div - restoring unsigned divider
// One quotient bit per cycle, one-cycle done pulse.
// ----------------------------------------------------------------------------
module wsfi_div #(
    parameter int NW = wsfi_pkg::NUM_W,
    parameter int DW = wsfi_pkg::DEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [DW:0]   r_rem, trial, n_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num;
    logic [CW-1:0] r_cnt;
    logic          r_done, qbit;

    always_comb begin
        trial = {r_rem[DW-1:0], r_num[NW-1]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? (trial - {1'b0, r_den}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start)
                r_cnt <= CW'(NW);
            else if (r_cnt != '0)
                r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_num <= {r_num[NW-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

/* src/wsfi_front.sv */
// ----------------------------------------------------------------------------
// wsfi_front - item intake and job queue
// Clamps the point, forms segment deltas and queues the job for the back end.
// ----------------------------------------------------------------------------
module wsfi_front #(
    parameter int GRID_DIM = wsfi_pkg::GRID_DIM_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wsfi_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output wsfi_pkg::t_job  o_job
);
    localparam int DEPTH = wsfi_pkg::QDEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [9:0] PMAX = 10'(GRID_DIM - 1);

    wsfi_pkg::t_job r_q [DEPTH];
    wsfi_pkg::t_job job;
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic [9:0]     px, py;
    logic           do_pop;

    always_comb begin
        px = (32'(i_item.point_x) > GRID_DIM - 1) ? PMAX : i_item.point_x;
        py = (32'(i_item.point_y) > GRID_DIM - 1) ? PMAX : i_item.point_y;
        job.px_q    = {px, 8'b0};
        job.py_q    = {py, 8'b0};
        job.x0      = i_item.start_x;
        job.y0      = i_item.start_y;
        job.dx      = 25'(i_item.end_x) - 25'(i_item.start_x);
        job.dy      = 25'(i_item.end_y) - 25'(i_item.start_y);
        job.cur     = i_item.current;
        job.prior   = i_item.prior_field;
        job.restart = i_item.restart;
    end

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + PW'(1);
            if (do_pop)
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + PW'(1);
            if (i_push && !do_pop)
                r_cnt <= r_cnt + CW'(1);
            else if (!i_push && do_pop)
                r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_q[r_wp] <= job;
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rp];

endmodule

/* src/wsfi_back.sv */
// ----------------------------------------------------------------------------
// wsfi_back - segment integration engine
// Sequencer around one shared multiplier, a square root unit and a divider.
// ----------------------------------------------------------------------------
module wsfi_back #(
    parameter int MAX_STEPS = wsfi_pkg::MAX_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsfi_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  wsfi_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    output wsfi_pkg::t_result o_result
);
    localparam int KW = $clog2(MAX_STEPS + 1);

    wsfi_pkg::t_bstate r_state, n_state;
    wsfi_pkg::t_job    r_job;
    wsfi_pkg::t_result r_res, n_res;
    logic                r_valid, n_valid;
    logic signed [47:0]  r_peak, n_peak;
    logic [KW-1:0]       r_k, n_k;
    logic [25:0]         r_d, n_d;
    logic [24:0]         r_len, n_len;
    logic signed [17:0]  r_ux, r_uy, n_ux, n_uy;
    logic signed [47:0]  r_prod, n_prod, r_cross, n_cross;
    logic signed [27:0]  r_fu, r_fv, n_fu, n_fv;
    logic [55:0]         r_sq, n_sq;
    logic [27:0]         r_r, n_r;
    logic [16:0]         r_sn, n_sn;
    logic [62:0]         r_sum, n_sum;
    logic [94:0]         r_acc, n_acc;
    logic [1:0]          r_ci, n_ci;
    logic                r_ovf, n_ovf;

    logic signed [32:0]  m_a, m_b;
    logic signed [65:0]  m_p;
    logic [7:0]          s_eff;
    logic [24:0]         adx, ady;
    logic [47:0]         xmag, dv_num, dv_q;
    logic [55:0]         dv_den;
    logic                dv_start, dv_done, sq_start, sq_done;
    logic [27:0]         sq_root;
    logic signed [47:0]  wq, wpos, fpos;
    logic [63:0]         sum_t, sum64;
    logic [31:0]         cmag;
    logic [78:0]         cq;
    logic [47:0]         contrib;
    logic signed [49:0]  fld, prior50;
    logic signed [47:0]  field, peak_base;
    logic [17:0]         q18;

    wsfi_sqrt #(.W(wsfi_pkg::SQ_W)) u_sqrt (
        .i_clk, .i_rst_n, .i_start(sq_start), .i_rad(r_sq),
        .o_done(sq_done), .o_root(sq_root)
    );

    wsfi_div #(.NW(wsfi_pkg::NUM_W), .DW(wsfi_pkg::DEN_W)) u_div (
        .i_clk, .i_rst_n, .i_start(dv_start), .i_num(dv_num), .i_den(dv_den),
        .o_done(dv_done), .o_quo(dv_q)
    );

    assign m_p = m_a * m_b;

    always_comb begin
        s_eff = (i_cfg.step_length == 8'd0) ? 8'd1 : i_cfg.step_length;
        adx   = r_job.dx[24] ? 25'(-r_job.dx) : 25'(r_job.dx);
        ady   = r_job.dy[24] ? 25'(-r_job.dy) : 25'(r_job.dy);
        xmag  = r_cross[47] ? 48'(-r_cross) : 48'(r_cross);
        cmag  = r_job.cur[31] ? 32'(-r_job.cur) : 32'(r_job.cur);
        sum64 = {1'b0, r_sum};
        sum_t = sum64 + 64'(dv_q);
        // unit direction magnitude never exceeds 65536
        q18   = dv_q[17:0];
        // truncate toward zero on the scaled sample offset
        wq    = r_prod[47] ? ((r_prod + 48'sd65535) >>> 16) : (r_prod >>> 16);
        if (r_state == wsfi_pkg::S_FU) begin
            wpos = {{24{r_job.x0[23]}}, r_job.x0} + wq;
            fpos = $signed({30'b0, r_job.px_q});
        end else begin
            wpos = {{24{r_job.y0[23]}}, r_job.y0} + wq;
            fpos = $signed({30'b0, r_job.py_q});
        end
        cq      = r_acc[94:16];
        contrib = (cq > 79'(wsfi_pkg::CONTRIB_CAP)) ? wsfi_pkg::CONTRIB_CAP : cq[47:0];
        prior50 = {{2{r_job.prior[47]}}, r_job.prior};
        if (r_job.cur[31]) begin
            fld = prior50 - $signed({2'b0, contrib});
            if (fld < wsfi_pkg::FIELD_MIN)
                fld = wsfi_pkg::FIELD_MIN;
        end else begin
            fld = prior50 + $signed({2'b0, contrib});
            if (fld > wsfi_pkg::FIELD_MAX)
                fld = wsfi_pkg::FIELD_MAX;
        end
        field     = fld[47:0];
        peak_base = r_job.restart ? 48'sd0 : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsfi_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_peak  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_peak  <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_job <= i_job;
        r_res   <= n_res;
        r_k     <= n_k;
        r_d     <= n_d;
        r_len   <= n_len;
        r_ux    <= n_ux;
        r_uy    <= n_uy;
        r_prod  <= n_prod;
        r_cross <= n_cross;
        r_fu    <= n_fu;
        r_fv    <= n_fv;
        r_sq    <= n_sq;
        r_r     <= n_r;
        r_sn    <= n_sn;
        r_sum   <= n_sum;
        r_acc   <= n_acc;
        r_ci    <= n_ci;
        r_ovf   <= n_ovf;
    end

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_valid = 1'b0;
        n_peak  = r_peak;
        n_k     = r_k;
        n_d     = r_d;
        n_len   = r_len;
        n_ux    = r_ux;
        n_uy    = r_uy;
        n_prod  = r_prod;
        n_cross = r_cross;
        n_fu    = r_fu;
        n_fv    = r_fv;
        n_sq    = r_sq;
        n_r     = r_r;
        n_sn    = r_sn;
        n_sum   = r_sum;
        n_acc   = r_acc;
        n_ci    = r_ci;
        n_ovf   = r_ovf;
        o_pop   = 1'b0;
        m_a     = '0;
        m_b     = '0;
        sq_start = 1'b0;
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = '0;

        unique case (r_state)
            wsfi_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_k     = '0;
                    n_d     = '0;
                    n_sum   = '0;
                    n_ovf   = 1'b0;
                    n_state = wsfi_pkg::S_LMX;
                end
            end
            wsfi_pkg::S_LMX: begin
                m_a     = 33'(r_job.dx);
                m_b     = 33'(r_job.dx);
                n_sq    = m_p[55:0];
                n_state = wsfi_pkg::S_LMY;
            end
            wsfi_pkg::S_LMY: begin
                m_a     = 33'(r_job.dy);
                m_b     = 33'(r_job.dy);
                n_sq    = r_sq + m_p[55:0];
                n_state = wsfi_pkg::S_LSQ;
            end
            wsfi_pkg::S_LSQ: begin
                sq_start = 1'b1;
                n_state  = wsfi_pkg::S_LSQW;
            end
            wsfi_pkg::S_LSQW: begin
                if (sq_done) begin
                    n_len = sq_root[24:0];
                    if (sq_root == '0) begin
                        n_ux    = '0;
                        n_uy    = '0;
                        n_state = wsfi_pkg::S_SAMP;
                    end else begin
                        n_state = wsfi_pkg::S_DXD;
                    end
                end
            end
            wsfi_pkg::S_DXD: begin
                dv_start = 1'b1;
                dv_num   = {7'b0, adx, 16'b0};
                dv_den   = {31'b0, r_len};
                n_state  = wsfi_pkg::S_DXW;
            end
            wsfi_pkg::S_DXW: begin
                if (dv_done) begin
                    n_ux    = r_job.dx[24] ? 18'(-$signed(q18)) : $signed(q18);
                    n_state = wsfi_pkg::S_DYD;
                end
            end
            wsfi_pkg::S_DYD: begin
                dv_start = 1'b1;
                dv_num   = {7'b0, ady, 16'b0};
                dv_den   = {31'b0, r_len};
                n_state  = wsfi_pkg::S_DYW;
            end
            wsfi_pkg::S_DYW: begin
                if (dv_done) begin
                    n_uy    = r_job.dy[24] ? 18'(-$signed(q18)) : $signed(q18);
                    n_state = wsfi_pkg::S_SAMP;
                end
            end
            wsfi_pkg::S_SAMP: begin
                // walk ends when the distance reaches the length or the limit hits
                if (r_d >= {1'b0, r_len}) begin
                    n_acc   = '0;
                    n_ci    = '0;
                    n_state = wsfi_pkg::S_CM;
                end else if (r_k == KW'(MAX_STEPS)) begin
                    n_ovf   = 1'b1;
                    n_acc   = '0;
                    n_ci    = '0;
                    n_state = wsfi_pkg::S_CM;
                end else begin
                    n_state = wsfi_pkg::S_WX;
                end
            end
            wsfi_pkg::S_WX: begin
                m_a     = {7'b0, r_d};
                m_b     = 33'(r_ux);
                n_prod  = m_p[47:0];
                n_state = wsfi_pkg::S_FU;
            end
            wsfi_pkg::S_FU: begin
                n_fu    = 28'(fpos - wpos);
                n_state = wsfi_pkg::S_WY;
            end
            wsfi_pkg::S_WY: begin
                m_a     = {7'b0, r_d};
                m_b     = 33'(r_uy);
                n_prod  = m_p[47:0];
                n_state = wsfi_pkg::S_FV;
            end
            wsfi_pkg::S_FV: begin
                n_fv    = 28'(fpos - wpos);
                n_state = wsfi_pkg::S_RR1;
            end
            wsfi_pkg::S_RR1: begin
                m_a     = 33'(r_fu);
                m_b     = 33'(r_fu);
                n_sq    = m_p[55:0];
                n_state = wsfi_pkg::S_RR2;
            end
            wsfi_pkg::S_RR2: begin
                m_a     = 33'(r_fv);
                m_b     = 33'(r_fv);
                n_sq    = r_sq + m_p[55:0];
                n_state = wsfi_pkg::S_RSQ;
            end
            wsfi_pkg::S_RSQ: begin
                sq_start = 1'b1;
                n_state  = wsfi_pkg::S_RSQW;
            end
            wsfi_pkg::S_RSQW: begin
                if (sq_done) begin
                    n_r = sq_root;
                    if (sq_root == '0 || sq_root < {12'b0, i_cfg.exclusion_radius}) begin
                        n_k     = r_k + KW'(1);
                        n_d     = r_d + 26'(s_eff);
                        n_state = wsfi_pkg::S_SAMP;
                    end else begin
                        n_state = wsfi_pkg::S_CR1;
                    end
                end
            end
            wsfi_pkg::S_CR1: begin
                m_a     = 33'(r_ux);
                m_b     = 33'(r_fv);
                n_prod  = m_p[47:0];
                n_state = wsfi_pkg::S_CR2;
            end
            wsfi_pkg::S_CR2: begin
                m_a     = 33'(r_uy);
                m_b     = 33'(r_fu);
                n_cross = r_prod - m_p[47:0];
                n_state = wsfi_pkg::S_SND;
            end
            wsfi_pkg::S_SND: begin
                dv_start = 1'b1;
                dv_num   = xmag;
                dv_den   = {28'b0, r_r};
                n_state  = wsfi_pkg::S_SNW;
            end
            wsfi_pkg::S_SNW: begin
                if (dv_done) begin
                    n_sn    = (dv_q > 48'd65536) ? 17'd65536 : dv_q[16:0];
                    n_state = wsfi_pkg::S_TM;
                end
            end
            wsfi_pkg::S_TM: begin
                m_a     = {25'b0, s_eff};
                m_b     = {16'b0, r_sn};
                n_prod  = m_p[47:0];
                n_state = wsfi_pkg::S_TMD;
            end
            wsfi_pkg::S_TMD: begin
                dv_start = 1'b1;
                dv_num   = {r_prod[23:0], 24'b0};
                dv_den   = r_sq;
                n_state  = wsfi_pkg::S_TMW;
            end
            wsfi_pkg::S_TMW: begin
                if (dv_done) begin
                    n_sum   = (sum_t > {1'b0, wsfi_pkg::SUM_CAP}) ?
                              wsfi_pkg::SUM_CAP : sum_t[62:0];
                    n_k     = r_k + KW'(1);
                    n_d     = r_d + 26'(s_eff);
                    n_state = wsfi_pkg::S_SAMP;
                end
            end
            wsfi_pkg::S_CM: begin
                // sum times |current|, one 16-bit slice of the sum per cycle
                m_a     = {17'b0, sum64[{r_ci, 4'b0} +: 16]};
                m_b     = {1'b0, cmag};
                n_acc   = r_acc + (95'(m_p[47:0]) << {r_ci, 4'b0});
                n_ci    = r_ci + 2'd1;
                if (r_ci == 2'd3)
                    n_state = wsfi_pkg::S_FLD;
            end
            wsfi_pkg::S_FLD: begin
                n_res.field_value   = field;
                n_res.peak_value    = (field > peak_base) ? field : peak_base;
                n_res.step_overflow = r_ovf;
                n_peak  = (field > peak_base) ? field : peak_base;
                n_valid = 1'b1;
                n_state = wsfi_pkg::S_IDLE;
            end
            default: n_state = wsfi_pkg::S_IDLE;
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_k_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != wsfi_pkg::S_IDLE) |-> (r_k <= KW'(MAX_STEPS)))
        else $error("sample counter past limit");
    a_peak_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_peak[47])
        else $error("running peak negative");
    a_peak_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.peak_value >= r_res.field_value))
        else $error("peak below field");
    a_sum_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wsfi_pkg::S_CM) |-> (r_sum <= wsfi_pkg::SUM_CAP))
        else $error("sum above cap");
`endif

endmodule

/* tb/sv/wire_segment_field_integrator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wire_segment_field_integrator_test - self-checking bench for the integrator
// Drives directed and random segment transfers under several register settings
// and sender idle profiles; every result is checked against an in-bench
// fixed-point model of the line segment field sum.
// ----------------------------------------------------------------------------
module wire_segment_field_integrator_test;

    localparam int  N_RANDOM  = 930;
    localparam int  STEP_CAP  = 1024;
    localparam longint unsigned SUM_LIMIT  = 64'h4000_0000_0000_0000;
    localparam longint unsigned CONTR_LIM  = 64'h0000_8000_0000_0000;
    localparam longint          FLD_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          FLD_LO     = -64'sh0000_8000_0000_0000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    wsfi_pkg::t_item   i_item = '0;
    logic              i_cfg_we = 1'b0;
    logic [wsfi_pkg::CFG_IDX_W-1:0] i_cfg_idx = wsfi_pkg::CFG_STEP;
    logic [15:0]       i_cfg_data = '0;
    logic              o_valid;
    wsfi_pkg::t_result o_result;

    // model copy of the registers and the running peak
    logic [7:0]        step_reg = wsfi_pkg::STEP_RST;
    logic [15:0]       excl_reg = wsfi_pkg::EXCL_RST;
    longint            peak_track = 0;

    wsfi_pkg::t_result field_queue[$];
    int                errors = 0;
    int                idle_pct = 0;

    wire_segment_field_integrator uut (.*);

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // fixed-point model
    // ------------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // full field sum for one segment; updates the tracked peak
    function automatic wsfi_pkg::t_result integrate_segment(wsfi_pkg::t_item it);
        wsfi_pkg::t_result res;
        longint          x0 = it.start_x, y0 = it.start_y;
        longint          dx = longint'(it.end_x) - x0;
        longint          dy = longint'(it.end_y) - y0;
        longint          cur = it.current;
        longint          prior = it.prior_field;
        longint unsigned stp = (step_reg == 0) ? 1 : step_reg;
        longint unsigned len, cnt, sum = 0, contrib, c, hi, lo, rr, r, sn, term;
        longint          ux = 0, uy = 0, pxq, pyq, d, wx, wy, fu, fv, fld;
        logic            ovf = 1'b0;

        len = int_sqrt(magn(dx) * magn(dx) + magn(dy) * magn(dy));
        pxq = longint'(it.point_x) * 256;
        pyq = longint'(it.point_y) * 256;
        cnt = (len + stp - 1) / stp;
        if (cnt > STEP_CAP) begin
            cnt = STEP_CAP;
            ovf = 1'b1;
        end
        if (len != 0) begin
            ux = (dx * 65536) / longint'(len);
            uy = (dy * 65536) / longint'(len);
        end
        for (longint unsigned k = 0; k < cnt; k++) begin
            d  = longint'(k * stp);
            wx = x0 + (d * ux) / 65536;
            wy = y0 + (d * uy) / 65536;
            fu = pxq - wx;
            fv = pyq - wy;
            rr = magn(fu) * magn(fu) + magn(fv) * magn(fv);
            r  = int_sqrt(rr);
            if (r == 0 || r < excl_reg) continue;   // exclusion, incl. on-point
            sn = magn(ux * fv - uy * fu) / r;
            if (sn > 65536) sn = 65536;
            term = ((stp * sn) << 24) / rr;
            if (sum > SUM_LIMIT - term) sum = SUM_LIMIT;
            else sum += term;
        end

        c  = magn(cur);
        hi = sum >> 16;
        lo = sum & 64'hFFFF;
        if (hi != 0 && c > CONTR_LIM / hi) contrib = CONTR_LIM;
        else begin
            contrib = hi * c + ((lo * c) >> 16);
            if (contrib > CONTR_LIM) contrib = CONTR_LIM;
        end

        if (cur < 0) begin
            fld = prior - longint'(contrib);
            if (fld < FLD_LO) fld = FLD_LO;
        end else begin
            fld = prior + longint'(contrib);
            if (fld > FLD_HI) fld = FLD_HI;
        end

        if (it.restart) peak_track = 0;
        if (fld > peak_track) peak_track = fld;

        res.field_value   = fld[47:0];
        res.peak_value    = peak_track[47:0];
        res.step_overflow = ovf;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // transfer helpers
    // ------------------------------------------------------------------------
    // start is left high on return unless an idle gap is drawn, so back-to-back transfers need no re-raise
    task automatic send_item(wsfi_pkg::t_item it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        field_queue.push_back(integrate_segment(it));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // register writes only once the block has drained
    task automatic write_reg(logic [wsfi_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        start <= 1'b0;
        wait (field_queue.size() == 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == wsfi_pkg::CFG_STEP) step_reg = val[7:0];
        else excl_reg = val;
    endtask

    function automatic wsfi_pkg::t_item seg_item(int px, int py, longint sx, longint sy,
                                                 longint ex, longint ey, longint cur,
                                                 longint prior, bit rst);
        wsfi_pkg::t_item it;
        it.point_x = 10'(px);  it.point_y = 10'(py);
        it.start_x = 24'(sx);  it.start_y = 24'(sy);
        it.end_x   = 24'(ex);  it.end_y   = 24'(ey);
        it.current = 32'(cur); it.prior_field = 48'(prior);
        it.restart = rst;
        return it;
    endfunction

    // short segments keep the walk to a handful of samples
    function automatic wsfi_pkg::t_item rand_item();
        wsfi_pkg::t_item it;
        longint stp = (step_reg == 0) ? 1 : step_reg;
        longint span, sx, sy, ox, oy;
        it.point_x = 10'($urandom_range(0, 1023));
        it.point_y = 10'($urandom_range(0, 1023));
        if ($urandom_range(3) != 0) begin
            sx = longint'(it.point_x) * 256 + $urandom_range(0, 4096) - 2048;
            sy = longint'(it.point_y) * 256 + $urandom_range(0, 4096) - 2048;
        end else begin
            sx = $signed(24'($urandom));
            sy = $signed(24'($urandom));
        end
        span = ($urandom_range(19) == 0) ? 0 : stp * $urandom_range(0, 3) +
               $urandom_range(0, stp);
        ox = $urandom_range(0, span);
        oy = $urandom_range(0, span);
        if ($urandom_range(1)) ox = -ox;
        if ($urandom_range(1)) oy = -oy;
        if (sx + ox > 8388607 || sx + ox < -8388608) ox = -ox;
        if (sy + oy > 8388607 || sy + oy < -8388608) oy = -oy;
        it.start_x = 24'(sx);       it.start_y = 24'(sy);
        it.end_x   = 24'(sx + ox);  it.end_y   = 24'(sy + oy);
        it.current = $urandom;
        it.prior_field = ($urandom_range(1)) ? 48'({$urandom, $urandom}) :
                         48'($signed(32'($urandom)));
        it.restart = ($urandom_range(7) == 0);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // result check: o_valid lasts one cycle, no back-pressure
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        wsfi_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (field_queue.size() == 0) begin
                $display("%0t: unexpected result field=%h", $realtime,
                         o_result.field_value);
                errors++;
            end else begin
                want = field_queue.pop_front();
                if (o_result.field_value !== want.field_value) begin
                    $display("%0t: field_value exp %h got %h", $realtime,
                             want.field_value, o_result.field_value);
                    errors++;
                end
                if (o_result.peak_value !== want.peak_value) begin
                    $display("%0t: peak_value exp %h got %h", $realtime,
                             want.peak_value, o_result.peak_value);
                    errors++;
                end
                if (o_result.step_overflow !== want.step_overflow) begin
                    $display("%0t: step_overflow exp %b got %b", $realtime,
                             want.step_overflow, o_result.step_overflow);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        idle_pct = 0;
        write_reg(wsfi_pkg::CFG_STEP, 16'd16);
        write_reg(wsfi_pkg::CFG_EXCL, 16'd0);
        // sample exactly on the grid point is skipped even with radius 0
        send_item(seg_item(10, 10, 2560, 2560, 2640, 2560, 32'sh0001_0000, 0, 1));
        // zero-length segments at the coordinate extremes
        send_item(seg_item(0, 0, -8388608, -8388608, -8388608, -8388608,
                           32'sh8000_0000, 0, 0));
        send_item(seg_item(1023, 1023, 8388607, 8388607, 8388607, 8388607,
                           2147483647, 48'sh7FFF_FFFF_FFFF, 0));
        // near samples, full-scale current: saturate both ways
        send_item(seg_item(1, 1, 0, 300, 60, 300, 2147483647,
                           48'sh7FFF_FFFF_0000, 0));
        send_item(seg_item(1, 1, 0, 300, 60, 300, 32'sh8000_0000,
                           -48'sh7FFF_FFFF_0000, 0));
        send_item(seg_item(1023, 0, 261888, 40, 261888, -20, 12345, -5, 0));
        send_item(seg_item(0, 1023, -100, 261888, 20, 261800, -70000, 77, 1));
        send_item(seg_item(512, 512, 131000, 131000, 131050, 131030, 0, 1000, 0));
        send_item(seg_item(700, 3, 8388607, -8388608, 8388560, -8388550,
                           2147483647, -1, 1));

        // zero step counts as one; a long segment hits the step limit
        write_reg(wsfi_pkg::CFG_STEP, 16'd0);
        write_reg(wsfi_pkg::CFG_EXCL, 16'hFFFF);
        send_item(seg_item(5, 5, 1280, 1280, 2380, 1280, 65536, 0, 0));
        send_item(seg_item(5, 5, 1280, 1280, 1283, 1281, 65536, 3, 0));
        write_reg(wsfi_pkg::CFG_EXCL, 16'd256);
        send_item(seg_item(5, 5, 1280, 1100, 1283, 1102, 65536, 3, 0));

        // widest step
        write_reg(wsfi_pkg::CFG_STEP, 16'd255);
        write_reg(wsfi_pkg::CFG_EXCL, 16'd1);
        send_item(seg_item(4, 4, 0, 0, 700, 500, 32'sh7FFF_0000, -100, 1));
        send_item(seg_item(4, 4, 1024, 1024, 1024, 2000, -32'sh0000_8000, 50, 0));
    endtask

    // random segments across a set of register settings and idle profiles
    task automatic test_random();
        int steps[6] = '{26, 1, 255, 64, 7, 140};
        int excls[6] = '{256, 0, 65535, 40, 900, 3};
        int idles[6] = '{0, 47, 16, 0, 47, 16};
        for (int p = 0; p < 6; p++) begin
            write_reg(wsfi_pkg::CFG_STEP, 16'(steps[p]));
            write_reg(wsfi_pkg::CFG_EXCL, 16'(excls[p]));
            idle_pct = idles[p];
            for (int n = 0; n < N_RANDOM / 6; n++) send_item(rand_item());
        end
        start <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        wait (field_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
